### src/cpsac_pkg.sv
// shared types, constants and widths for the camera pan servo controller
package cpsac_pkg;

    // field widths
    localparam int AngleW    = 8;
    localparam int PixW      = 10;
    localparam int StepW     = 7;
    localparam int FovW      = 8;
    localparam int TurnW     = 5;
    localparam int ModeW     = 2;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 10;

    // shared multiply and divide unit sizing
    localparam int MagW      = PixW + 1;        // |x_left + x_right - 2*centre| <= 2046
    localparam int DivW      = PixW + 1;        // 2*image_width
    localparam int ProdW     = MagW + FovW;     // product and quotient magnitude
    localparam int ResW      = ProdW + 1;       // signed correction
    localparam int MulSteps  = FovW;
    localparam int DivSteps  = ProdW;
    localparam int CntW      = $clog2(DivSteps);
    localparam int SumW      = ResW + 1;        // angle plus correction

    // angle limits and reset values
    localparam logic [AngleW-1:0]   AngleMax        = 8'd180;
    localparam logic [AngleW-1:0]   AngleReset      = 8'd90;
    localparam logic [StepW-1:0]    ScanStepReset   = 7'd10;
    localparam logic [StepW-1:0]    ManualStepReset = 7'd5;
    localparam logic [PixW-1:0]     CentreReset     = 10'd320;
    localparam logic [FovW-1:0]     FovReset        = 8'd60;
    localparam logic [PixW-1:0]     WidthReset      = 10'd640;

    // camera and car mode codes
    localparam logic [ModeW-1:0]    CamManual       = 2'd0;
    localparam logic [ModeW-1:0]    CamScan         = 2'd1;
    localparam logic [ModeW-1:0]    CarModeCamOk    = 2'd0;

    // item kinds
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_JOY    = 2'd1,
        OP_CAM    = 2'd2,
        OP_TARGET = 2'd3
    } op_t;

    // register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_SCAN_STEP    = 3'd0,
        CFG_MANUAL_STEP  = 3'd1,
        CFG_IMAGE_CENTRE = 3'd2,
        CFG_FOV          = 3'd3,
        CFG_IMAGE_WIDTH  = 3'd4
    } cfg_idx_t;

    // top level sequencer
    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_CALC,
        CTL_PARK
    } ctl_state_t;

    // multiply and divide unit sequencer
    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_state_t;

    // request into the shared unit: sign * (mag_a * mag_b) / divisor
    typedef struct packed {
        logic                start;
        logic [MagW-1:0]     mag_a;
        logic [FovW-1:0]     mag_b;
        logic [DivW-1:0]     divisor;
        logic                neg;
    } md_req_t;

    // response from the shared unit
    typedef struct packed {
        logic                       done;
        logic signed [ResW-1:0]     result;
    } md_rsp_t;

endpackage

### src/cpsac_intf.sv
// channel interfaces: command items, angle results and register writes

// command item channel
interface cpsac_cmd_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         opcode;
    logic [cpsac_pkg::ModeW-1:0]        drive_mode_in;
    logic                               start_in;
    logic [cpsac_pkg::ModeW-1:0]        cam_mode_in;
    logic signed [cpsac_pkg::TurnW-1:0] turn_in;
    logic [cpsac_pkg::PixW-1:0]         x_left;
    logic [cpsac_pkg::PixW-1:0]         x_right;

    modport source (
        output valid, opcode, drive_mode_in, start_in, cam_mode_in, turn_in, x_left, x_right,
        input  ready
    );
    modport sink (
        input  valid, opcode, drive_mode_in, start_in, cam_mode_in, turn_in, x_left, x_right,
        output ready
    );
endinterface

// angle result channel
interface cpsac_angle_if;
    logic                           valid;
    logic                           ready;
    logic [cpsac_pkg::AngleW-1:0]   angle;

    modport source (output valid, angle, input ready);
    modport sink   (input valid, angle, output ready);
endinterface

// register write channel
interface cpsac_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cpsac_pkg::CfgIdxW-1:0]  index;
    logic [cpsac_pkg::CfgDataW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/cpsac_muldiv.sv
// shared iterative unit: shift-add multiply then restoring divide, sign applied at the end
module cpsac_muldiv (
    input  logic                clk,
    input  logic                rst_n,
    input  cpsac_pkg::md_req_t  req,
    output cpsac_pkg::md_rsp_t  rsp
);
    import cpsac_pkg::*;

    md_state_t              state_reg, state_next;
    logic [CntW-1:0]        cnt_reg, cnt_next;
    logic                   done_reg, done_next;
    logic [ProdW-1:0]       prod_reg, prod_next;
    logic [ProdW-1:0]       mcand_reg, mcand_next;
    logic [FovW-1:0]        mplier_reg, mplier_next;
    logic [DivW-1:0]        rem_reg, rem_next;
    logic [DivW-1:0]        div_reg, div_next;
    logic                   neg_reg, neg_next;

    // the one adder, shared by both phases
    logic [ResW-1:0]        alu_a, alu_b, alu_sum;
    logic                   alu_cin;
    logic [DivW:0]          trial;
    logic                   fits;

    assign trial   = {rem_reg, prod_reg[ProdW-1]};
    assign alu_sum = alu_a + alu_b + ResW'(alu_cin);
    assign fits    = ~alu_sum[ResW-1];

    // adder operand select
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_cin = 1'b0;
        unique case (state_reg)
            MD_MUL:
            begin
                alu_a = {1'b0, prod_reg};
                alu_b = mplier_reg[0] ? {1'b0, mcand_reg} : '0;
            end
            MD_DIV:
            begin
                alu_a   = ResW'(trial);
                alu_b   = ~ResW'(div_reg);
                alu_cin = 1'b1;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            MD_IDLE: if (req.start) state_next = MD_MUL;
            MD_MUL:  if (cnt_reg == '0) state_next = MD_DIV;
            MD_DIV:  if (cnt_reg == '0) state_next = MD_IDLE;
            default: state_next = MD_IDLE;
        endcase
    end

    // datapath and counter updates
    always_comb
    begin
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        prod_next   = prod_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        neg_next    = neg_reg;
        unique case (state_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    prod_next   = '0;
                    mcand_next  = ProdW'(req.mag_a);
                    mplier_next = req.mag_b;
                    div_next    = req.divisor;
                    neg_next    = req.neg;
                    cnt_next    = CntW'(MulSteps - 1);
                end
            end
            MD_MUL:
            begin
                prod_next   = alu_sum[ProdW-1:0];
                mcand_next  = {mcand_reg[ProdW-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[FovW-1:1]};
                if (cnt_reg == '0)
                begin
                    cnt_next = CntW'(DivSteps - 1);
                    rem_next = '0;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            MD_DIV:
            begin
                rem_next  = fits ? alu_sum[DivW-1:0] : trial[DivW-1:0];
                prod_next = {prod_reg[ProdW-2:0], fits};
                if (cnt_reg == '0)
                    done_next = 1'b1;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // operand and result registers
    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        neg_reg    <= neg_next;
    end

    // signed quotient, held until the next start
    assign rsp.done   = done_reg;
    assign rsp.result = neg_reg ? -$signed({1'b0, prod_reg}) : $signed({1'b0, prod_reg});

endmodule

### src/camera_pan_servo_angle_controller.sv
// top level of the camera pan servo controller: item decode, state and angle sequencing
//
//  channel | dir | beat contents                                          | accepted when
//  cmd     | in  | opcode, drive_mode_in, start_in, cam_mode_in, turn_in, | valid & ready
//          |     | x_left, x_right                                        |
//  pan     | out | angle                                                  | valid & ready
//  cfg     | in  | index, data                                            | valid & ready
//
//  joystick, camera and target beats are done once taken; a started tick runs in
//  the shared multiply/divide unit (start, 8 multiply steps, 19 divide steps, result).
//  reset puts the angle at 90 and the control registers at their defaults; no clearing
//  pass. one result register: a tick may be taken while the last angle waits, and its
//  own angle is parked in the unit until the result register frees. cfg is always ready.
module camera_pan_servo_angle_controller (
    input  logic        clk,
    input  logic        rst_n,
    cpsac_cmd_if.sink   cmd,
    cpsac_angle_if.source pan,
    cpsac_cfg_if.sink   cfg
);
    import cpsac_pkg::*;

    ctl_state_t             state_reg, state_next;

    // configuration registers
    logic [StepW-1:0]       scan_step_reg;
    logic [StepW-1:0]       manual_step_reg;
    logic [PixW-1:0]        image_centre_reg;
    logic [FovW-1:0]        fov_reg;
    logic [PixW-1:0]        image_width_reg;

    // controller state
    logic [AngleW-1:0]      pan_angle_reg, pan_angle_next;
    logic                   upward_reg, upward_next;
    logic [ModeW-1:0]       cam_mode_reg;
    logic signed [TurnW-1:0] turn_reg;
    logic                   follow_reg;
    logic [PixW-1:0]        target_left_reg;
    logic [PixW-1:0]        target_right_reg;
    logic [ModeW-1:0]       drive_mode_reg;
    logic                   started_reg;

    // result register
    logic                   out_valid_reg;
    logic [AngleW-1:0]      out_angle_reg;

    md_req_t                req;
    md_rsp_t                rsp;

    logic                   cmd_beat;
    logic                   tick_go;
    logic                   slot_free;
    logic                   out_write;
    op_t                    op;

    // follow and manual operands
    logic [MagW-1:0]        pix_sum;
    logic [MagW-1:0]        centre_x2;
    logic                   pix_neg;
    logic [MagW-1:0]        pix_mag;
    logic [TurnW-1:0]       turn_mag;
    logic signed [SumW-1:0] angle_sum;

    assign op        = op_t'(cmd.opcode);
    assign cmd_beat  = cmd.valid & cmd.ready;
    assign tick_go   = cmd_beat & (op == OP_TICK) & started_reg;
    assign slot_free = ~out_valid_reg | pan.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CTL_IDLE: if (tick_go) state_next = CTL_CALC;
            CTL_CALC:
            begin
                if (rsp.done)
                    state_next = slot_free ? CTL_IDLE : CTL_PARK;
            end
            CTL_PARK: if (slot_free) state_next = CTL_IDLE;
            default:  state_next = CTL_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        cmd.ready = 1'b0;
        out_write = 1'b0;
        unique case (state_reg)
            CTL_IDLE: cmd.ready = 1'b1;
            CTL_CALC: out_write = rsp.done & slot_free;
            CTL_PARK: out_write = slot_free;
            default:  cmd.ready = 1'b0;
        endcase
    end

    // pixel offset from the centre, as sign and magnitude
    assign pix_sum   = {1'b0, target_left_reg} + {1'b0, target_right_reg};
    assign centre_x2 = {image_centre_reg, 1'b0};
    assign pix_neg   = pix_sum < centre_x2;
    assign pix_mag   = pix_neg ? (centre_x2 - pix_sum) : (pix_sum - centre_x2);
    assign turn_mag  = turn_reg[TurnW-1] ? TurnW'(-turn_reg) : TurnW'(turn_reg);

    // operands for the shared unit, by tick kind
    always_comb
    begin
        req.start   = tick_go;
        req.mag_a   = '0;
        req.mag_b   = '0;
        req.divisor = DivW'(1);
        req.neg     = 1'b0;
        if (follow_reg)
        begin
            if (image_width_reg != '0)
            begin
                req.mag_a   = pix_mag;
                req.mag_b   = fov_reg;
                req.divisor = {image_width_reg, 1'b0};
                req.neg     = pix_neg;
            end
        end
        else if (cam_mode_reg == CamManual)
        begin
            req.mag_a = MagW'(turn_mag);
            req.mag_b = FovW'(manual_step_reg);
            req.neg   = turn_reg[TurnW-1];
        end
        else if (cam_mode_reg == CamScan)
        begin
            req.mag_a = MagW'(scan_step_reg);
            req.mag_b = FovW'(1);
            req.neg   = ~upward_reg;
        end
    end

    cpsac_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // new angle and clamp
    assign angle_sum = $signed({{(SumW-AngleW){1'b0}}, pan_angle_reg}) + SumW'(rsp.result);

    always_comb
    begin
        pan_angle_next = angle_sum[AngleW-1:0];
        upward_next    = upward_reg;
        if (angle_sum >= $signed(SumW'(AngleMax)))
        begin
            pan_angle_next = AngleMax;
            upward_next    = 1'b0;
        end
        else if (angle_sum <= $signed(SumW'(0)))
        begin
            pan_angle_next = '0;
            upward_next    = 1'b1;
        end
    end

    // sequencer register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= CTL_IDLE;
        else
            state_reg <= state_next;
    end

    // register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_step_reg    <= ScanStepReset;
            manual_step_reg  <= ManualStepReset;
            image_centre_reg <= CentreReset;
            fov_reg          <= FovReset;
            image_width_reg  <= WidthReset;
        end
        else if (cfg.valid & cfg.ready)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_SCAN_STEP:    scan_step_reg    <= cfg.data[StepW-1:0];
                CFG_MANUAL_STEP:  manual_step_reg  <= cfg.data[StepW-1:0];
                CFG_IMAGE_CENTRE: image_centre_reg <= cfg.data[PixW-1:0];
                CFG_FOV:          fov_reg          <= cfg.data[FovW-1:0];
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg.data[PixW-1:0];
                default:          scan_step_reg    <= scan_step_reg;
            endcase
        end
    end

    // item decode and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pan_angle_reg    <= AngleReset;
            upward_reg       <= 1'b1;
            cam_mode_reg     <= CamManual;
            turn_reg         <= '0;
            follow_reg       <= 1'b0;
            target_left_reg  <= '0;
            target_right_reg <= '0;
            drive_mode_reg   <= '0;
            started_reg      <= 1'b0;
        end
        else
        begin
            if (cmd_beat)
            begin
                unique case (op)
                    OP_JOY:
                    begin
                        drive_mode_reg <= cmd.drive_mode_in;
                        started_reg    <= cmd.start_in;
                    end
                    OP_CAM:
                    begin
                        if (drive_mode_reg == CarModeCamOk)
                        begin
                            cam_mode_reg <= cmd.cam_mode_in;
                            turn_reg     <= cmd.turn_in;
                        end
                    end
                    OP_TARGET:
                    begin
                        target_left_reg  <= cmd.x_left;
                        target_right_reg <= cmd.x_right;
                        follow_reg       <= 1'b1;
                    end
                    OP_TICK:
                    begin
                        if (started_reg)
                            follow_reg <= 1'b0;
                    end
                    default:
                    begin
                        follow_reg <= follow_reg;
                    end
                endcase
            end
            if (out_write)
            begin
                pan_angle_reg <= pan_angle_next;
                upward_reg    <= upward_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_write)
            out_valid_reg <= 1'b1;
        else if (pan.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_write)
            out_angle_reg <= pan_angle_next;
    end

    assign pan.valid = out_valid_reg;
    assign pan.angle = out_angle_reg;

endmodule
